/* design/cal2unix_pkg.sv */
// Shared widths, constants and the month table for the calendar-to-epoch converter.
// No dependencies; compiled first.
package cal2unix_pkg;

    // field widths
    localparam int YRS_W  = 10;
    localparam int MON_W  = 8;
    localparam int DAY_W  = 5;
    localparam int HOUR_W = 5;
    localparam int MIN_W  = 6;
    localparam int SEC_W  = 6;
    localparam int OUT_W  = 36;

    // internal widths
    localparam int Q12_W   = 5;   // month_index / 12 <= 21
    localparam int MREM_W  = 4;   // month of year 0..11
    localparam int YOFF_W  = 11;  // year - 1900 <= 1044
    localparam int C100_W  = 4;   // (year - 1900) / 100 <= 10
    localparam int Q400_W  = 2;   // (year - 1600) / 400 <= 3
    localparam int Y365_W  = 19;
    localparam int DBM_W   = 9;
    localparam int DAYS_W  = 21;  // signed day count
    localparam int TOD_W   = 18;  // signed seconds within the day, dst applied
    localparam int TODP_W  = 17;
    localparam int PROD_W  = DAYS_W + 18;

    // reciprocal multipliers: exact over the operand ranges above
    localparam logic [7:0]  RECIP12      = 8'd171;
    localparam int          RECIP12_SH   = 11;
    localparam logic [10:0] RECIP100     = 11'd1311;
    localparam int          RECIP100_SH  = 17;

    localparam logic [MON_W-1:0]  MONTHS_PER_YEAR = 8'd12;
    localparam logic [YOFF_W-1:0] CENTURY         = 11'd100;
    localparam logic [YOFF_W-1:0] QUAD_OFFSET     = 11'd300;   // 1900 - 1600
    localparam logic [YOFF_W-1:0] QUAD_CENTURY    = 11'd400;
    localparam logic [8:0]        DAYS_PER_YEAR   = 9'd365;

    // 70 years of 365 days, the 1968-based leap term offset (68 / 4), and
    // the day-of-month origin of 1
    localparam logic [DAYS_W-2:0] DAY_BIAS = 20'd25568;

    localparam logic [TODP_W-1:0] SECS_PER_HOUR = 17'd3600;
    localparam logic [TODP_W-1:0] SECS_PER_MIN  = 17'd60;
    localparam logic [17:0]       SECS_PER_DAY  = 18'd86400;
    localparam logic signed [TOD_W-1:0] DST_SHIFT = 18'sd3600;

    function automatic logic [DBM_W-1:0] days_before_month(input logic [MREM_W-1:0] m);
        logic [DBM_W-1:0] d;
        case (m)
            4'd0:    d = 9'd0;
            4'd1:    d = 9'd31;
            4'd2:    d = 9'd59;
            4'd3:    d = 9'd90;
            4'd4:    d = 9'd120;
            4'd5:    d = 9'd151;
            4'd6:    d = 9'd181;
            4'd7:    d = 9'd212;
            4'd8:    d = 9'd243;
            4'd9:    d = 9'd273;
            4'd10:   d = 9'd304;
            4'd11:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

endpackage

/* design/cal2unix_in_if.sv */
// Input channel: valid/ready handshake carrying one broken-down calendar time.
// Depends on cal2unix_pkg.
interface cal2unix_in_if
    import cal2unix_pkg::*;
();
    logic              valid;
    logic              ready;
    logic [YRS_W-1:0]  years_since_1900;
    logic [MON_W-1:0]  month_index;
    logic [DAY_W-1:0]  day_of_month;
    logic [HOUR_W-1:0] hour_of_day;
    logic [MIN_W-1:0]  minute_of_hour;
    logic [SEC_W-1:0]  second_of_minute;
    logic              dst_active;

    modport source (
        output valid, years_since_1900, month_index, day_of_month,
               hour_of_day, minute_of_hour, second_of_minute, dst_active,
        input  ready
    );

    modport sink (
        input  valid, years_since_1900, month_index, day_of_month,
               hour_of_day, minute_of_hour, second_of_minute, dst_active,
        output ready
    );
endinterface

/* design/cal2unix_out_if.sv */
// Output channel: valid/ready handshake carrying signed seconds since the epoch.
// Depends on cal2unix_pkg.
interface cal2unix_out_if
    import cal2unix_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] epoch_seconds;

    modport source (
        output valid, epoch_seconds,
        input  ready
    );

    modport sink (
        input  valid, epoch_seconds,
        output ready
    );
endinterface

/* design/calendar_to_unix_seconds.sv */
// An accepted beat passes stages 1 to 6 in order; rsp carries the stage 6 result.
// Throughput: one beat per cycle; six pipeline stages advance together, and
// the whole pipe holds while the last stage has a result that is not taken.
// Reset: rst_n clears the stage valid bits only; the pipe comes up empty.
// Depends on cal2unix_pkg, cal2unix_in_if and cal2unix_out_if.
module calendar_to_unix_seconds
    import cal2unix_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    cal2unix_in_if.sink    req,
    cal2unix_out_if.source rsp
);

    localparam int STAGES = 6;

    logic [STAGES-1:0] vld_reg;
    logic [STAGES-1:0] vld_next;
    logic              adv;

    // stage 1: month carry quotient, time of day
    logic [Q12_W-1:0]        s1_q12_reg,  s1_q12_next;
    logic [MON_W-1:0]        s1_mon_reg;
    logic [YRS_W-1:0]        s1_yrs_reg;
    logic [DAY_W-1:0]        s1_mday_reg;
    logic signed [TOD_W-1:0] s1_tod_reg,  s1_tod_next;
    logic [15:0]             q12_prod;
    logic [TODP_W-1:0]       tod_pos;

    // stage 2: year offset, month of year
    logic [YOFF_W-1:0]       s2_y_reg,    s2_y_next;
    logic [MREM_W-1:0]       s2_mrem_reg, s2_mrem_next;
    logic [DAY_W-1:0]        s2_mday_reg;
    logic signed [TOD_W-1:0] s2_tod_reg;
    logic [MON_W-1:0]        mon_sub;

    // stage 3: century and quad-century quotients, year days
    logic [YOFF_W-1:0]       s3_y_reg;
    logic [MREM_W-1:0]       s3_mrem_reg;
    logic [DAY_W-1:0]        s3_mday_reg;
    logic signed [TOD_W-1:0] s3_tod_reg;
    logic [C100_W-1:0]       s3_c100_reg, s3_c100_next;
    logic [Q400_W-1:0]       s3_q400_reg, s3_q400_next;
    logic [Y365_W-1:0]       s3_y365_reg, s3_y365_next;
    logic [21:0]             c100_prod;
    logic [YOFF_W-1:0]       z_quad;

    // stage 4: day count
    logic signed [DAYS_W-1:0] s4_days_reg, s4_days_next;
    logic signed [TOD_W-1:0]  s4_tod_reg;
    logic                     leap;
    logic [YOFF_W-1:0]        s3_z;
    logic [DAYS_W-2:0]        day_pos;
    logic [DAYS_W-2:0]        day_neg;

    // stage 5: day seconds
    logic signed [OUT_W-1:0]  s5_dsec_reg, s5_dsec_next;
    logic signed [TOD_W-1:0]  s5_tod_reg;
    logic signed [PROD_W-1:0] dsec_prod;

    // stage 6: result
    logic signed [OUT_W-1:0]  s6_out_reg, s6_out_next;

    assign adv       = !vld_reg[STAGES-1] || rsp.ready;
    assign req.ready = adv;
    assign vld_next  = {vld_reg[STAGES-2:0], req.valid};

    // ---- stage 1 logic
    always_comb
    begin
        q12_prod    = 16'(req.month_index) * 16'(RECIP12);
        s1_q12_next = q12_prod[RECIP12_SH +: Q12_W];
        tod_pos     = TODP_W'(req.hour_of_day) * SECS_PER_HOUR
                    + TODP_W'(req.minute_of_hour) * SECS_PER_MIN
                    + TODP_W'(req.second_of_minute);
        s1_tod_next = $signed({1'b0, tod_pos}) - (req.dst_active ? DST_SHIFT : '0);
    end

    // ---- stage 2 logic
    always_comb
    begin
        mon_sub      = s1_mon_reg - MON_W'(s1_q12_reg) * MONTHS_PER_YEAR;
        s2_mrem_next = mon_sub[MREM_W-1:0];
        s2_y_next    = YOFF_W'(s1_yrs_reg) + YOFF_W'(s1_q12_reg);
    end

    // ---- stage 3 logic
    always_comb
    begin
        c100_prod    = 22'(s2_y_reg) * 22'(RECIP100);
        s3_c100_next = c100_prod[RECIP100_SH +: C100_W];
        z_quad       = s2_y_reg + QUAD_OFFSET;
        s3_q400_next = Q400_W'(z_quad >= QUAD_CENTURY)
                     + Q400_W'(z_quad >= YOFF_W'(800))
                     + Q400_W'(z_quad >= YOFF_W'(1200));
        s3_y365_next = Y365_W'(s2_y_reg) * Y365_W'(DAYS_PER_YEAR);
    end

    // ---- stage 4 logic
    always_comb
    begin
        s3_z = s3_y_reg + QUAD_OFFSET;
        // leap: divisible by 4, and not a century unless a quad century
        leap = (s3_y_reg[1:0] == 2'b00)
            && ((s3_y_reg != YOFF_W'(s3_c100_reg) * CENTURY)
                || (s3_z == YOFF_W'(s3_q400_reg) * QUAD_CENTURY));
        day_pos = (DAYS_W-1)'(s3_y365_reg)
                + (DAYS_W-1)'(days_before_month(s3_mrem_reg))
                + (DAYS_W-1)'(s3_y_reg[YOFF_W-1:2])
                + (DAYS_W-1)'(s3_q400_reg)
                + (DAYS_W-1)'(s3_mday_reg);
        day_neg = DAY_BIAS + (DAYS_W-1)'(s3_c100_reg)
                + (DAYS_W-1)'(leap && (s3_mrem_reg < MREM_W'(2)));
        s4_days_next = $signed({1'b0, day_pos}) - $signed({1'b0, day_neg});
    end

    // ---- stage 5 / 6 logic
    always_comb
    begin
        dsec_prod    = PROD_W'(s4_days_reg) * $signed(PROD_W'(SECS_PER_DAY));
        s5_dsec_next = dsec_prod[OUT_W-1:0];
        s6_out_next  = s5_dsec_reg + OUT_W'(s5_tod_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_q12_reg  <= s1_q12_next;
            s1_mon_reg  <= req.month_index;
            s1_yrs_reg  <= req.years_since_1900;
            s1_mday_reg <= req.day_of_month;
            s1_tod_reg  <= s1_tod_next;

            s2_y_reg    <= s2_y_next;
            s2_mrem_reg <= s2_mrem_next;
            s2_mday_reg <= s1_mday_reg;
            s2_tod_reg  <= s1_tod_reg;

            s3_y_reg    <= s2_y_reg;
            s3_mrem_reg <= s2_mrem_reg;
            s3_mday_reg <= s2_mday_reg;
            s3_tod_reg  <= s2_tod_reg;
            s3_c100_reg <= s3_c100_next;
            s3_q400_reg <= s3_q400_next;
            s3_y365_reg <= s3_y365_next;

            s4_days_reg <= s4_days_next;
            s4_tod_reg  <= s3_tod_reg;

            s5_dsec_reg <= s5_dsec_next;
            s5_tod_reg  <= s4_tod_reg;

            s6_out_reg  <= s6_out_next;
        end
    end

    assign rsp.valid         = vld_reg[STAGES-1];
    assign rsp.epoch_seconds = s6_out_reg;

    // reciprocal divide by 12 leaves a month of year in range
    a_month_rem: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[1] |-> (s2_mrem_reg < MREM_W'(12)))
        else $error("month remainder out of range");

    // reciprocal divide by 100 gives the true quotient
    a_century_quot: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[2] |-> ((s3_y_reg - YOFF_W'(s3_c100_reg) * CENTURY) < CENTURY))
        else $error("century quotient wrong");

    // a stalled result blocks new beats
    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && !rsp.ready) |-> !req.ready)
        else $error("input taken while output stalled");

    // an accepted beat reaches stage 1 on the next edge
    a_beat_enters: assert property (@(posedge clk) disable iff (!rst_n)
        (req.valid && req.ready) |=> vld_reg[0])
        else $error("accepted beat lost at stage 1");

endmodule
